/* hdl/keyword_source_lexer_macros.svh */
// ---------------------------------------------------------------------------
// keyword source lexer assertion macros
// shared concurrent assertion forms for the checker
// ---------------------------------------------------------------------------
`ifndef KEYWORD_SOURCE_LEXER_MACROS_SVH
`define KEYWORD_SOURCE_LEXER_MACROS_SVH

// checked outside reset
`define KSL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define KSL_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/ksl_pkg.sv */
// ---------------------------------------------------------------------------
// ksl_pkg
// types, kind codes and keyword table for the keyword source lexer
// ---------------------------------------------------------------------------
`default_nettype none

package ksl_pkg;

   localparam int KSL_MAX_TEXT_LEN = 65536;
   localparam int TOKEN_TEXT_CAP   = 64;
   localparam int NUM_KW           = 31;
   localparam int TQ_DEPTH         = 4;
   localparam int TQ_AW            = $clog2(TQ_DEPTH);
   localparam int LIMIT_RESET      = 1024;

   localparam logic [5:0]  LEN_MAX   = 6'(TOKEN_TEXT_CAP - 1);
   localparam logic [16:0] LIMIT_TOP = 17'd65536;

   localparam logic [5:0] KIND_IDENT   = 6'd31;
   localparam logic [5:0] KIND_NUMBER  = 6'd32;
   localparam logic [5:0] KIND_STRING  = 6'd33;
   localparam logic [5:0] KIND_EQ      = 6'd34;
   localparam logic [5:0] KIND_NE      = 6'd35;
   localparam logic [5:0] KIND_LE      = 6'd36;
   localparam logic [5:0] KIND_GE      = 6'd37;
   localparam logic [5:0] KIND_ASSIGN  = 6'd38;
   localparam logic [5:0] KIND_PLUS    = 6'd39;
   localparam logic [5:0] KIND_MINUS   = 6'd40;
   localparam logic [5:0] KIND_ARROW   = 6'd41;
   localparam logic [5:0] KIND_STAR    = 6'd42;
   localparam logic [5:0] KIND_SLASH   = 6'd43;
   localparam logic [5:0] KIND_PERCENT = 6'd44;
   localparam logic [5:0] KIND_LPAREN  = 6'd45;
   localparam logic [5:0] KIND_RPAREN  = 6'd46;
   localparam logic [5:0] KIND_LBRACE  = 6'd47;
   localparam logic [5:0] KIND_RBRACE  = 6'd48;
   localparam logic [5:0] KIND_COMMA   = 6'd49;
   localparam logic [5:0] KIND_SEMI    = 6'd50;
   localparam logic [5:0] KIND_LT      = 6'd51;
   localparam logic [5:0] KIND_GT      = 6'd52;
   localparam logic [5:0] KIND_COLON   = 6'd53;
   localparam logic [5:0] KIND_LBRACK  = 6'd54;
   localparam logic [5:0] KIND_RBRACK  = 6'd55;
   localparam logic [5:0] KIND_DOT     = 6'd56;
   localparam logic [5:0] KIND_END     = 6'd57;
   localparam logic [5:0] KIND_NONE    = 6'd0;

   typedef enum logic [2:0] {
      LM_IDLE, LM_IDENT, LM_NUMBER, LM_STRING, LM_LINE, LM_BLOCK, LM_PEND
   } lex_mode_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       end_of_text;
   } ksl_req_type;

   typedef struct packed {
      logic [5:0]  kind;
      logic [15:0] token_index;
      logic [15:0] start_offset;
      logic [5:0]  text_length;
      logic        overflow;
      logic        last_of_item;
   } ksl_rsp_type;

   typedef struct packed {
      logic [1:0]  num;
      ksl_rsp_type w0;
      ksl_rsp_type w1;
   } ksl_push_type;

   // keyword text, right aligned, first character in the highest used byte
   localparam logic [95:0] KW_TEXT [NUM_KW] = '{
      96'("ring"), 96'("module"), 96'("generators"), 96'("relations"),
      96'("homomorphism"), 96'("in"), 96'h696e7465676572735f6d6f64, 96'("rationals"),
      96'h66726565_5f6d6f64_756c65, 96'("define"), 96'("as"), 96'("where"),
      96'("case"), 96'("of"), 96'("recursive"), 96'h6669786564_5f706f696e74,
      96'("morphism"), 96'("endomorphism"), 96'("kernel"), 96'("image"),
      96'("compose"), 96'("apply"), 96'("map"), 96'("fold"), 96'("unfold"),
      96'("colimit"), 96'("limit"), 96'("filter"), 96'("lambda"),
      96'("with"), 96'("initial")
   };

   localparam logic [3:0] KW_LEN [NUM_KW] = '{
      4'd4, 4'd6, 4'd10, 4'd9, 4'd12, 4'd2, 4'd12, 4'd9, 4'd11, 4'd6,
      4'd2, 4'd5, 4'd4, 4'd2, 4'd9, 4'd11, 4'd8, 4'd12, 4'd6, 4'd5,
      4'd7, 4'd5, 4'd3, 4'd4, 4'd6, 4'd7, 4'd5, 4'd6, 4'd6, 4'd4, 4'd7
   };

   function automatic logic [7:0] kw_byte(input logic [4:0] k, input logic [3:0] i);
      logic [3:0]  r;
      logic [95:0] t;
      r = KW_LEN[k] - 4'd1 - i;
      t = KW_TEXT[k] >> {r, 3'b000};
      return t[7:0];
   endfunction

   function automatic logic [5:0] single_kind(input logic [7:0] c);
      logic [5:0] k;
      case (c)
         "=":     k = KIND_ASSIGN;
         "+":     k = KIND_PLUS;
         "-":     k = KIND_MINUS;
         "*":     k = KIND_STAR;
         "/":     k = KIND_SLASH;
         "%":     k = KIND_PERCENT;
         "(":     k = KIND_LPAREN;
         ")":     k = KIND_RPAREN;
         "{":     k = KIND_LBRACE;
         "}":     k = KIND_RBRACE;
         ",":     k = KIND_COMMA;
         ";":     k = KIND_SEMI;
         "<":     k = KIND_LT;
         ">":     k = KIND_GT;
         ":":     k = KIND_COLON;
         "[":     k = KIND_LBRACK;
         "]":     k = KIND_RBRACK;
         ".":     k = KIND_DOT;
         default: k = KIND_NONE;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

/* hdl/ksl_front.sv */
// ---------------------------------------------------------------------------
// ksl_front
// byte classifier and token former, up to two tokens per byte
// ---------------------------------------------------------------------------
`default_nettype none

module ksl_front
   import ksl_pkg::*;
#(
   parameter int MAX_TEXT_LEN = KSL_MAX_TEXT_LEN
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         accept,
   input  wire ksl_req_type  req_data,
   input  wire logic         csr_we,
   input  wire logic [16:0]  csr_wdata,
   output ksl_push_type      push
);

   localparam int PosW = $clog2(MAX_TEXT_LEN + 1);

   lex_mode_type       mode_ff, mode_in;
   logic [7:0]         pend_ff, pend_in;
   logic               star_ff, star_in;
   logic [15:0]        start_ff, start_in;
   logic [5:0]         len_ff, len_in;
   logic [NUM_KW-1:0]  alive_ff, alive_in;
   logic [PosW-1:0]    pos_ff, pos_in;
   logic [15:0]        cnt_ff, cnt_in;
   logic               ovf_ff, ovf_in;
   logic [16:0]        limit_ff, limit_in;

   logic [16:0]        cap;
   logic [PosW+15:0]   pos_wide;
   logic [15:0]        pos16;
   logic [7:0]         c;
   logic               is_space, is_digit, is_alpha, is_word;
   logic [NUM_KW-1:0]  step_match, first_match_kw;
   logic [5:0]         ident_kind;
   logic [5:0]         flush_kind;
   logic [5:0]         flush_len;
   logic               flush_emits;
   logic [5:0]         two_kind;

   assign c        = req_data.ch;
   assign pos_wide = {16'd0, pos_ff};
   assign pos16    = pos_wide[15:0];
   assign is_space = c inside {[8'd9:8'd13], 8'd32};
   assign is_digit = c inside {["0":"9"]};
   assign is_alpha = c inside {["a":"z"], ["A":"Z"]};
   assign is_word  = is_alpha || is_digit || (c == "_");

   always_comb begin
      if (limit_ff > LIMIT_TOP) begin
         cap = LIMIT_TOP - 17'd1;
      end else if (limit_ff == 17'd0) begin
         cap = 17'd0;
      end else begin
         cap = limit_ff - 17'd1;
      end
   end

   always_comb begin
      ident_kind = KIND_IDENT;
      for (int k = 0; k < NUM_KW; k++) begin
         step_match[k]     = (len_ff < {2'b00, KW_LEN[k]}) && (kw_byte(5'(k), len_ff[3:0]) == c);
         first_match_kw[k] = (kw_byte(5'(k), 4'd0) == c);
         if (alive_ff[k] && (len_ff == {2'b00, KW_LEN[k]})) begin
            ident_kind = 6'(k);
         end
      end
   end

   always_comb begin
      flush_emits = 1'b1;
      flush_len   = len_ff;
      case (mode_ff)
         LM_IDENT:  flush_kind = ident_kind;
         LM_NUMBER: flush_kind = KIND_NUMBER;
         LM_STRING: flush_kind = KIND_STRING;
         LM_PEND: begin
            flush_kind  = single_kind(pend_ff);
            flush_len   = 6'd1;
            flush_emits = (pend_ff != "!");
         end
         default: begin
            flush_kind  = KIND_NONE;
            flush_emits = 1'b0;
         end
      endcase
   end

   always_comb begin
      two_kind = KIND_NONE;
      if (c == "=") begin
         case (pend_ff)
            "=":     two_kind = KIND_EQ;
            "!":     two_kind = KIND_NE;
            "<":     two_kind = KIND_LE;
            ">":     two_kind = KIND_GE;
            default: two_kind = KIND_NONE;
         endcase
      end else if ((c == ">") && (pend_ff == "-")) begin
         two_kind = KIND_ARROW;
      end
   end

   // next state and token emission
   always_comb begin
      logic [16:0]  cnt;
      logic         ovf;
      logic         e0_v, e1_v, do_flush, do_start;
      ksl_rsp_type  e0, e1;

      mode_in  = mode_ff;
      pend_in  = pend_ff;
      star_in  = star_ff;
      start_in = start_ff;
      len_in   = len_ff;
      alive_in = alive_ff;
      pos_in   = pos_ff;
      limit_in = csr_we ? csr_wdata : limit_ff;
      cnt      = {1'b0, cnt_ff};
      ovf      = ovf_ff;
      e0_v     = 1'b0;
      e1_v     = 1'b0;
      do_flush = 1'b0;
      do_start = 1'b0;
      e0       = '0;
      e1       = '0;

      if (accept) begin
         if (req_data.end_of_text) begin
            if (!ovf && (cnt < cap) && flush_emits) begin
               e0_v           = 1'b1;
               e0.kind        = flush_kind;
               e0.token_index = cnt[15:0];
               e0.start_offset = start_ff;
               e0.text_length = flush_len;
               cnt            = cnt + 17'd1;
               ovf            = (cnt >= cap);
            end
            e1_v            = 1'b1;
            e1.kind         = KIND_END;
            e1.token_index  = cnt[15:0];
            e1.start_offset = pos16;
            e1.overflow     = ovf || (cnt >= cap);
            mode_in  = LM_IDLE;
            pend_in  = '0;
            star_in  = 1'b0;
            start_in = '0;
            len_in   = '0;
            alive_in = '1;
            pos_in   = '0;
            cnt      = '0;
            ovf      = 1'b0;
         end else if (ovf || (cnt >= cap)) begin
            ovf = 1'b1;
         end else if (pos_ff < PosW'(MAX_TEXT_LEN)) begin
            pos_in = pos_ff + PosW'(1);
            case (mode_ff)
               LM_IDENT: begin
                  if (is_word) begin
                     if (len_ff < LEN_MAX) begin
                        alive_in = alive_ff & step_match;
                        len_in   = len_ff + 6'd1;
                     end
                  end else begin
                     do_flush = 1'b1;
                     do_start = 1'b1;
                  end
               end
               LM_NUMBER: begin
                  if (is_digit) begin
                     if (len_ff < LEN_MAX) len_in = len_ff + 6'd1;
                  end else begin
                     do_flush = 1'b1;
                     do_start = 1'b1;
                  end
               end
               LM_STRING: begin
                  if (c == "\"") begin
                     do_flush = 1'b1;
                  end else if (len_ff < LEN_MAX) begin
                     len_in = len_ff + 6'd1;
                  end
               end
               LM_LINE: begin
                  if (c == 8'd10) mode_in = LM_IDLE;
               end
               LM_BLOCK: begin
                  if (star_ff && (c == "/")) begin
                     mode_in = LM_IDLE;
                  end else begin
                     star_in = (c == "*");
                  end
               end
               LM_PEND: begin
                  if ((pend_ff == "/") && (c == "/")) begin
                     mode_in = LM_LINE;
                  end else if ((pend_ff == "/") && (c == "*")) begin
                     mode_in = LM_BLOCK;
                     star_in = 1'b0;
                  end else if (two_kind != KIND_NONE) begin
                     mode_in         = LM_IDLE;
                     e0_v            = 1'b1;
                     e0.kind         = two_kind;
                     e0.token_index  = cnt[15:0];
                     e0.start_offset = start_ff;
                     e0.text_length  = 6'd2;
                     cnt             = cnt + 17'd1;
                     ovf             = (cnt >= cap);
                  end else begin
                     do_flush = 1'b1;
                     do_start = 1'b1;
                  end
               end
               default: begin
                  mode_in  = LM_IDLE;
                  do_start = 1'b1;
               end
            endcase

            if (do_flush) begin
               mode_in = LM_IDLE;
               if (flush_emits) begin
                  if (cnt >= cap) begin
                     ovf = 1'b1;
                  end else begin
                     e0_v            = 1'b1;
                     e0.kind         = flush_kind;
                     e0.token_index  = cnt[15:0];
                     e0.start_offset = start_ff;
                     e0.text_length  = flush_len;
                     cnt             = cnt + 17'd1;
                     ovf             = (cnt >= cap);
                  end
               end
            end

            if (do_start && !ovf) begin
               if (is_space) begin
                  mode_in = mode_in;
               end else if (is_alpha || (c == "_")) begin
                  mode_in  = LM_IDENT;
                  start_in = pos16;
                  len_in   = 6'd1;
                  alive_in = first_match_kw;
               end else if (is_digit) begin
                  mode_in  = LM_NUMBER;
                  start_in = pos16;
                  len_in   = 6'd1;
               end else if (c == "\"") begin
                  mode_in  = LM_STRING;
                  start_in = pos16 + 16'd1;
                  len_in   = 6'd0;
               end else if (c inside {"/", "=", "!", "<", ">", "-"}) begin
                  mode_in  = LM_PEND;
                  pend_in  = c;
                  start_in = pos16;
               end else if (single_kind(c) != KIND_NONE) begin
                  if (cnt >= cap) begin
                     ovf = 1'b1;
                  end else begin
                     e1_v            = 1'b1;
                     e1.kind         = single_kind(c);
                     e1.token_index  = cnt[15:0];
                     e1.start_offset = pos16;
                     e1.text_length  = 6'd1;
                     cnt             = cnt + 17'd1;
                     ovf             = (cnt >= cap);
                  end
               end
            end
         end
      end

      cnt_in = cnt[15:0];
      ovf_in = ovf;

      push.num = {1'b0, e0_v} + {1'b0, e1_v};
      push.w1  = e1;
      push.w1.last_of_item = 1'b1;
      push.w0  = e0_v ? e0 : e1;
      push.w0.last_of_item = !(e0_v && e1_v);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= LM_IDLE;
         pend_ff  <= '0;
         star_ff  <= 1'b0;
         start_ff <= '0;
         len_ff   <= '0;
         alive_ff <= '1;
         pos_ff   <= '0;
         cnt_ff   <= '0;
         ovf_ff   <= 1'b0;
         limit_ff <= 17'(LIMIT_RESET);
      end else begin
         mode_ff  <= mode_in;
         pend_ff  <= pend_in;
         star_ff  <= star_in;
         start_ff <= start_in;
         len_ff   <= len_in;
         alive_ff <= alive_in;
         pos_ff   <= pos_in;
         cnt_ff   <= cnt_in;
         ovf_ff   <= ovf_in;
         limit_ff <= limit_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/ksl_tokq.sv */
// ---------------------------------------------------------------------------
// ksl_tokq
// token queue, up to two words in and one word out per cycle while rsp_stall is low
// ---------------------------------------------------------------------------
`default_nettype none

module ksl_tokq
   import ksl_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire ksl_push_type  push,
   output logic              full,
   output logic              rsp_valid,
   input  wire logic          rsp_stall,
   output ksl_rsp_type       rsp_data
);

   ksl_rsp_type       q_ff [TQ_DEPTH];
   ksl_rsp_type       q_in [TQ_DEPTH];
   logic [TQ_AW-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [TQ_AW:0]    cnt_ff, cnt_in;
   logic              pop;
   logic [TQ_AW-1:0]  wr_next;

   assign rsp_valid = (cnt_ff != '0);
   assign rsp_data  = q_ff[rd_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign full      = (cnt_ff > (TQ_AW+1)'(TQ_DEPTH - 2));
   assign wr_next   = wr_ff + TQ_AW'(1);

   always_comb begin
      q_in = q_ff;
      if (push.num != 2'd0) q_in[wr_ff] = push.w0;
      if (push.num == 2'd2) q_in[wr_next] = push.w1;
      wr_in  = wr_ff + TQ_AW'(push.num);
      rd_in  = rd_ff + TQ_AW'(pop);
      cnt_in = cnt_ff + (TQ_AW+1)'(push.num) - (TQ_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/keyword_source_lexer.sv */
// ---------------------------------------------------------------------------
// keyword_source_lexer
// streaming tokenizer: byte in, kind/index/offset/length word out
// ---------------------------------------------------------------------------
//  port group  dir  handshake           word
//  req_        in   req_valid/req_stall ksl_req_type (ch, end_of_text)
//  rsp_        out  rsp_valid/rsp_stall ksl_rsp_type (kind .. last_of_item)
//  csr_        in   csr_we              token limit, 17 bits
//
// one byte taken per cycle while req_stall is low; each byte yields zero to two tokens
// tokens leave one per cycle while rsp_stall is low, from a four-word queue behind the lexer
// req_stall is high while the queue holds more than two words
// synchronous reset; the token limit resets to 1024
// ---------------------------------------------------------------------------
`default_nettype none

module keyword_source_lexer
   import ksl_pkg::*;
#(
   parameter int MAX_TEXT_LEN = KSL_MAX_TEXT_LEN
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic             req_stall,
   input  wire ksl_req_type  req_data,
   output logic             rsp_valid,
   input  wire logic         rsp_stall,
   output ksl_rsp_type      rsp_data,
   input  wire logic         csr_we,
   input  wire logic [16:0]  csr_wdata
);

   ksl_push_type push;
   logic         full;
   logic         accept;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   ksl_front #(
      .MAX_TEXT_LEN (MAX_TEXT_LEN)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .push      (push)
   );

   ksl_tokq u_tokq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

/* hdl/ksl_checker.sv */
// ---------------------------------------------------------------------------
// ksl_checker
// port level checks for the keyword source lexer
// ---------------------------------------------------------------------------
`default_nettype none

`include "keyword_source_lexer_macros.svh"

module ksl_checker
   import ksl_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_valid,
   input wire logic         req_stall,
   input wire ksl_req_type  req_data,
   input wire logic         rsp_valid,
   input wire logic         rsp_stall,
   input wire ksl_rsp_type  rsp_data
);

   `KSL_ASSERT_ALWAYS(a_empty_after_reset, clock, reset |=> !rsp_valid && !req_stall, "queue not empty after reset")

   `KSL_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "stalled word changed")

   `KSL_ASSERT(a_req_hold, clock, reset, req_valid && req_stall |=> req_valid && $stable(req_data), "stalled request changed")

   `KSL_ASSERT(a_ovf_on_end, clock, reset, rsp_valid && rsp_data.overflow |-> rsp_data.kind == KIND_END, "overflow on a non-end word")

   `KSL_ASSERT(a_end_shape, clock, reset, rsp_valid && (rsp_data.kind == KIND_END) |-> rsp_data.last_of_item && (rsp_data.text_length == 6'd0), "end word malformed")

endmodule

bind keyword_source_lexer ksl_checker u_ksl_checker (.*);

`default_nettype wire

/* sim/testbench.sv */
// ---------------------------------------------------------------------------
// testbench
// keyword source lexer: directed table and random source texts against a
// predictor; bursty sender, patterned receiver stall, several token limits
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;
   import ksl_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [5:0] KIND_RING = 6'd0;

   typedef struct {
      logic [7:0]  ch;
      bit          eot;
      bit          typed;
      ksl_rsp_type w;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   ksl_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   ksl_rsp_type rsp_data;
   logic        csr_we = 1'b0;
   logic [16:0] csr_wdata = '0;

   keyword_source_lexer i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #20ms;
      $display("** keyword_source_lexer: FAILED **");
      $finish;
   end

   // token predictor state
   lex_mode_type lmode;
   logic [7:0]   pend_ch;
   bit           star_seen;
   int unsigned  tok_start, tok_len, byte_pos, tok_count, limit_val;
   logic [30:0]  kw_alive;
   bit           ovf_flag;
   ksl_rsp_type  words [4];
   int           nwords;

   ksl_rsp_type  token_q [$];
   int           fails = 0, tokens_seen = 0, ovf_seen = 0, items_sent = 0, texts = 0;

   function automatic int unsigned token_cap();
      int unsigned l;
      l = (limit_val > 65536) ? 65536 : limit_val;
      return (l != 0) ? l - 1 : 0;
   endfunction

   function automatic void add_word(logic [5:0] k, int unsigned s, int unsigned n, bit o);
      if (nwords >= 4) return;
      words[nwords] = '{k, tok_count[15:0], s[15:0], n[5:0], o, 1'b0};
      nwords++;
   endfunction

   function automatic void emit_token(logic [5:0] k, int unsigned s, int unsigned n);
      int unsigned c;
      c = token_cap();
      if (ovf_flag || tok_count >= c) begin
         ovf_flag = 1;
         return;
      end
      add_word(k, s, n, 1'b0);
      tok_count++;
      if (tok_count >= c) ovf_flag = 1;
   endfunction

   function automatic bit is_ws(logic [7:0] c);
      return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic bit is_num(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic [7:0] kw_char(int k, int unsigned i);
      return KW_TEXT[k][(KW_LEN[k] - 1 - i) * 8 +: 8];
   endfunction

   function automatic void ident_add(logic [7:0] c);
      if (tok_len >= TOKEN_TEXT_CAP - 1) return;
      for (int k = 0; k < NUM_KW; k++)
         if (!(tok_len < KW_LEN[k] && kw_char(k, tok_len) == c)) kw_alive[k] = 1'b0;
      tok_len++;
   endfunction

   function automatic logic [5:0] op_kind(logic [7:0] c);
      case (c)
         "=": return KIND_ASSIGN;
         "+": return KIND_PLUS;
         "-": return KIND_MINUS;
         "*": return KIND_STAR;
         "/": return KIND_SLASH;
         "%": return KIND_PERCENT;
         "(": return KIND_LPAREN;
         ")": return KIND_RPAREN;
         "{": return KIND_LBRACE;
         "}": return KIND_RBRACE;
         ",": return KIND_COMMA;
         ";": return KIND_SEMI;
         "<": return KIND_LT;
         ">": return KIND_GT;
         ":": return KIND_COLON;
         "[": return KIND_LBRACK;
         "]": return KIND_RBRACK;
         ".": return KIND_DOT;
         default: return KIND_NONE;
      endcase
   endfunction

   function automatic void close_token();
      logic [5:0] k;
      case (lmode)
         LM_IDENT: begin
            k = KIND_IDENT;
            for (int i = 0; i < NUM_KW; i++)
               if (kw_alive[i] && KW_LEN[i] == tok_len) k = 6'(i);
            emit_token(k, tok_start, tok_len);
         end
         LM_NUMBER: emit_token(KIND_NUMBER, tok_start, tok_len);
         LM_STRING: emit_token(KIND_STRING, tok_start, tok_len);
         LM_PEND:   if (pend_ch != "!") emit_token(op_kind(pend_ch), tok_start, 1);
         default: ;
      endcase
      lmode = LM_IDLE;
   endfunction

   function automatic void open_token(logic [7:0] c, int unsigned p);
      if (is_ws(c)) return;
      if (is_letter(c) || c == "_") begin
         lmode = LM_IDENT; tok_start = p; tok_len = 0; kw_alive = '1;
         ident_add(c);
      end else if (is_num(c)) begin
         lmode = LM_NUMBER; tok_start = p; tok_len = 1;
      end else if (c == "\"") begin
         lmode = LM_STRING; tok_start = p + 1; tok_len = 0;
      end else if (c == "/" || c == "=" || c == "!" || c == "<" || c == ">" || c == "-") begin
         lmode = LM_PEND; pend_ch = c; tok_start = p;
      end else if (op_kind(c) != KIND_NONE) begin
         emit_token(op_kind(c), p, 1);
      end
   endfunction

   function automatic void lex_byte(logic [7:0] c, int unsigned p);
      logic [5:0] two;
      two = KIND_NONE;
      case (lmode)
         LM_IDENT: begin
            if (is_letter(c) || is_num(c) || c == "_") begin
               ident_add(c);
               return;
            end
            close_token();
         end
         LM_NUMBER: begin
            if (is_num(c)) begin
               if (tok_len < TOKEN_TEXT_CAP - 1) tok_len++;
               return;
            end
            close_token();
         end
         LM_STRING: begin
            if (c == "\"") close_token();
            else if (tok_len < TOKEN_TEXT_CAP - 1) tok_len++;
            return;
         end
         LM_LINE: begin
            if (c == 8'd10) lmode = LM_IDLE;
            return;
         end
         LM_BLOCK: begin
            if (star_seen && c == "/") lmode = LM_IDLE;
            else star_seen = (c == "*");
            return;
         end
         LM_PEND: begin
            if (pend_ch == "/" && c == "/") begin
               lmode = LM_LINE;
               return;
            end
            if (pend_ch == "/" && c == "*") begin
               lmode = LM_BLOCK; star_seen = 0;
               return;
            end
            if (c == "=") begin
               if (pend_ch == "=") two = KIND_EQ;
               else if (pend_ch == "!") two = KIND_NE;
               else if (pend_ch == "<") two = KIND_LE;
               else if (pend_ch == ">") two = KIND_GE;
            end else if (pend_ch == "-" && c == ">") two = KIND_ARROW;
            if (two != KIND_NONE) begin
               lmode = LM_IDLE;
               emit_token(two, tok_start, 2);
               return;
            end
            close_token();
         end
         default: lmode = LM_IDLE;
      endcase
      if (!ovf_flag) open_token(c, p);
   endfunction

   function automatic void new_text();
      lmode = LM_IDLE; pend_ch = 0; star_seen = 0; tok_start = 0; tok_len = 0;
      kw_alive = '1; byte_pos = 0; tok_count = 0; ovf_flag = 0;
   endfunction

   function automatic void predict_tokens(logic [7:0] c, bit eot);
      int unsigned cp;
      nwords = 0;
      cp = token_cap();
      if (eot) begin
         if (!ovf_flag && tok_count < cp) close_token();
         add_word(KIND_END, byte_pos, 0, ovf_flag || tok_count >= cp);
         new_text();
      end else if (ovf_flag || tok_count >= cp) begin
         ovf_flag = 1;
      end else if (byte_pos < KSL_MAX_TEXT_LEN) begin
         lex_byte(c, byte_pos);
         byte_pos++;
      end
      if (nwords > 2) nwords = 2;
      if (nwords > 0) words[nwords - 1].last_of_item = 1'b1;
   endfunction

   // sender: bursts and gaps
   int burst_left = 0;

   task automatic send_word(logic [7:0] c, bit eot, bit typed = 0, ksl_rsp_type w = '0);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= '{c, eot};
      do @(posedge clock); while (req_stall);
      items_sent++;
      predict_tokens(c, eot);
      if (typed) token_q.push_back(w);
      else for (int i = 0; i < nwords; i++) token_q.push_back(words[i]);
   endtask

   task automatic drain_and_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (token_q.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_limit(int unsigned v);
      drain_and_idle();
      csr_we    <= 1'b1;
      csr_wdata <= v[16:0];
      @(negedge clock);
      csr_we    <= 1'b0;
      limit_val = v;
   endtask

   // receiver stall pattern
   int unsigned stall_cyc = 0;

   always @(negedge clock) begin
      stall_cyc++;
      case ((items_sent / 97) % 4)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 2) == 0);
         2:       rsp_stall <= ((stall_cyc % 5) < 2);
         default: rsp_stall <= ($urandom_range(0, 9) < 7);
      endcase
   end

   always @(posedge clock) begin
      ksl_rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (token_q.size() == 0) begin
            $error("unexpected word kind=%0d", rsp_data.kind);
            fails++;
         end else begin
            e = token_q.pop_front();
            tokens_seen++;
            if (rsp_data.overflow) ovf_seen++;
            if (rsp_data.kind !== e.kind) begin
               $error("kind exp %0d got %0d", e.kind, rsp_data.kind); fails++;
            end
            if (rsp_data.token_index !== e.token_index) begin
               $error("token_index exp %0d got %0d", e.token_index, rsp_data.token_index);
               fails++;
            end
            if (rsp_data.start_offset !== e.start_offset) begin
               $error("start_offset exp %0d got %0d", e.start_offset, rsp_data.start_offset);
               fails++;
            end
            if (rsp_data.text_length !== e.text_length) begin
               $error("text_length exp %0d got %0d", e.text_length, rsp_data.text_length);
               fails++;
            end
            if (rsp_data.overflow !== e.overflow) begin
               $error("overflow exp %0d got %0d", e.overflow, rsp_data.overflow); fails++;
            end
            if (rsp_data.last_of_item !== e.last_of_item) begin
               $error("last_of_item exp %0d got %0d", e.last_of_item, rsp_data.last_of_item);
               fails++;
            end
         end
      end
   end

   // random source text
   task automatic send_text(int nfrag);
      logic [7:0] b [$];
      string      ops [23];
      string      s;
      int         n, k;
      ops = '{"==", "!=", "<=", ">=", "=", "+", "-", "->", "*", "/", "%", "(", ")",
              "{", "}", ",", ";", "<", ">", ":", "[", "]", "."};
      for (int f = 0; f < nfrag; f++) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               k = $urandom_range(0, NUM_KW - 1);
               n = KW_LEN[k];
               if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
               for (int i = 0; i < n; i++) b.push_back(kw_char(k, i));
               if ($urandom_range(0, 5) == 0) b.push_back("_");
            end
            2: begin
               n = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 75) : $urandom_range(1, 8);
               for (int i = 0; i < n; i++)
                  case ($urandom_range(0, 3))
                     0:       b.push_back(8'($urandom_range("A", "Z")));
                     1:       b.push_back(i == 0 ? "_" : 8'($urandom_range("0", "9")));
                     default: b.push_back(8'($urandom_range("a", "z")));
                  endcase
            end
            3: begin
               n = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 6);
               for (int i = 0; i < n; i++) b.push_back(8'($urandom_range("0", "9")));
            end
            4: begin
               b.push_back("\"");
               n = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 6);
               for (int i = 0; i < n; i++) b.push_back(8'($urandom_range(32, 126)) == "\"" ?
                  "q" : 8'($urandom_range(32, 126)));
               if ($urandom_range(0, 7) != 0) b.push_back("\"");
            end
            5, 6: begin
               s = ops[$urandom_range(0, 22)];
               for (int i = 0; i < s.len(); i++) b.push_back(s[i]);
            end
            7: begin
               b.push_back("/");
               if ($urandom_range(0, 1)) begin
                  b.push_back("/");
                  repeat ($urandom_range(0, 5)) b.push_back(8'($urandom_range(32, 126)));
                  if ($urandom_range(0, 7) != 0) b.push_back(8'd10);
               end else begin
                  b.push_back("*");
                  repeat ($urandom_range(0, 5)) b.push_back(8'($urandom_range(32, 126)));
                  if ($urandom_range(0, 7) != 0) begin
                     b.push_back("*");
                     b.push_back("/");
                  end
               end
            end
            8: b.push_back(8'($urandom_range(0, 255)));
            default: b.push_back($urandom_range(0, 1) ? 8'd32 : 8'($urandom_range(9, 13)));
         endcase
         if ($urandom_range(0, 2) != 0) b.push_back(8'd32);
      end
      foreach (b[i]) send_word(b[i], 1'b0);
      send_word(8'($urandom_range(0, 255)), 1'b1);
      texts++;
   endtask

   row_type steps [26] = '{
      '{8'h00, 1, 1, '{KIND_END, 16'd0, 16'd0, 6'd0, 1'b0, 1'b1}},
      '{"r", 0, 0, '0}, '{"i", 0, 0, '0}, '{"n", 0, 0, '0}, '{"g", 0, 0, '0},
      '{" ", 0, 1, '{KIND_RING, 16'd0, 16'd0, 6'd4, 1'b0, 1'b1}},
      '{8'h00, 0, 0, '0}, '{8'hFF, 0, 0, '0}, '{"!", 0, 0, '0},
      '{"=", 0, 1, '{KIND_NE, 16'd1, 16'd7, 6'd2, 1'b0, 1'b1}},
      '{"/", 0, 0, '0}, '{"*", 0, 0, '0}, '{"*", 0, 0, '0}, '{"/", 0, 0, '0},
      '{"-", 0, 0, '0},
      '{">", 0, 1, '{KIND_ARROW, 16'd2, 16'd13, 6'd2, 1'b0, 1'b1}},
      '{"9", 0, 0, '0},
      '{"/", 0, 1, '{KIND_NUMBER, 16'd3, 16'd15, 6'd1, 1'b0, 1'b1}},
      '{"/", 0, 0, '0}, '{"x", 0, 0, '0},
      '{8'h00, 1, 1, '{KIND_END, 16'd4, 16'd19, 6'd0, 1'b0, 1'b1}},
      '{"\"", 0, 0, '0}, '{"a", 0, 0, '0}, '{8'hFF, 1, 0, '0},
      '{"_", 0, 0, '0}, '{8'h00, 1, 0, '0}
   };

   initial begin
      int unsigned limits [6];
      limit_val = LIMIT_RESET;
      new_text();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (steps[i]) send_word(steps[i].ch, steps[i].eot, steps[i].typed, steps[i].w);

      limits = '{2, 3, 65535, 7, 65536, $urandom_range(2, 40)};
      foreach (limits[p]) begin
         write_limit(limits[p]);
         repeat (limits[p] < 10 ? 3 : 1) send_text($urandom_range(2, 14));
      end
      write_limit(LIMIT_RESET);
      while (items_sent < 1100) send_text($urandom_range(2, 14));

      drain_and_idle();
      repeat (20) @(posedge clock);
      $display("covered %0d texts, %0d input words, %0d tokens checked, %0d overflow ends",
               texts, items_sent, tokens_seen, ovf_seen);
      if (fails == 0 && token_q.size() == 0)
         $display("** keyword_source_lexer: PASSED **");
      else
         $display("** keyword_source_lexer: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire
